/* src/assert_macros.svh */
// Assertion macros shared by the sketch RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

/* src/dscms_pkg.sv */
// Types, constants and helpers for the delay-sum count-min sketch.
`default_nettype none

package dscms_pkg;

    localparam int ROWS        = 4;
    localparam int ROW_BUCKETS = 1024;
    localparam int FIELD_W     = 31;
    localparam int DELAY_W     = 24;
    localparam int BKT_W       = 10;
    localparam int ENTRIES     = ROWS * ROW_BUCKETS;
    localparam int ADDR_W      = $clog2(ENTRIES);
    localparam int ROWSEL_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DIVCNT_W    = $clog2(FIELD_W);
    localparam int WORD_W      = 2 * FIELD_W;

    localparam logic [FIELD_W-1:0] FIELD_MAX = {FIELD_W{1'b1}};

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_UPD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               command;
        logic [DELAY_W-1:0] delay;
        logic [BKT_W-1:0]   bucket_row0;
        logic [BKT_W-1:0]   bucket_row1;
        logic [BKT_W-1:0]   bucket_row2;
        logic [BKT_W-1:0]   bucket_row3;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] average;
        logic               empty_res;
        logic [FIELD_W-1:0] least_count;
        logic [FIELD_W-1:0] min_sum;
    } t_out;

    // Reduce a bucket index into the row by shifted compare/subtract;
    // only shifts that still fit below the index range take part.
    function automatic logic [BKT_W-1:0] row_mod(input logic [BKT_W-1:0] idx);
        logic [BKT_W-1:0] v;
        v = idx;
        for (int k = BKT_W - 1; k >= 0; k--) begin
            if ((ROW_BUCKETS << k) < (1 << BKT_W)) begin
                if (v >= BKT_W'(ROW_BUCKETS << k)) begin
                    v = v - BKT_W'(ROW_BUCKETS << k);
                end
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* src/dscms_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module dscms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/delay_sum_count_min_sketch_core.sv */
// Top level of the delay-sum count-min sketch: sequencer, row RAM and divider.
//
//  channel  dir  handshake                 payload
//  in       in   i_in_valid / o_in_ready   i_in_data  (t_in)
//  out      out  o_out_valid / i_out_ready o_out_data (t_out)
//
// After reset the bucket RAM is swept to zero, one entry a cycle; no item is taken
// until all ENTRIES (4096) entries have been cleared.
// Insert: per row a read (S_RD) then a write-back (S_UPD) through the one RAM.
// Query: each row is read in turn for the row minimums; when the count is nonzero the
// one-bit-per-cycle divider then forms FIELD_W (31) quotient bits, and S_DONE loads the result.
// The result sits in an output register; inserts keep flowing while it waits.
`default_nettype none
`include "assert_macros.svh"

module delay_sum_count_min_sketch_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire dscms_pkg::t_in  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output dscms_pkg::t_out      o_out_data
);

    import dscms_pkg::*;

    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic [ROWSEL_W-1:0]  r_row, n_row;
    t_cmd                 r_cmd, n_cmd;
    logic [DELAY_W-1:0]   r_delay, n_delay;
    logic [BKT_W-1:0]     r_bkt [ROWS];
    logic [BKT_W-1:0]     n_bkt [ROWS];
    logic [FIELD_W-1:0]   r_min_cnt, n_min_cnt;
    logic [FIELD_W-1:0]   r_min_sum, n_min_sum;
    logic [FIELD_W:0]     r_rem, n_rem;
    logic [FIELD_W-1:0]   r_quo, n_quo;
    logic [DIVCNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;

    logic [BKT_W-1:0]     in_bkt [4];
    logic [ADDR_W-1:0]    row_addr;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic [FIELD_W-1:0]   rd_cnt, rd_sum;
    logic [FIELD_W:0]     cnt_inc, sum_inc, rem_sh;
    logic [FIELD_W-1:0]   sat_cnt, sat_sum, min_cnt_now, min_sum_now;
    logic                 last_row;

    dscms_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (row_addr),
        .o_rdata (ram_rdata)
    );

    assign in_bkt[0] = i_in_data.bucket_row0;
    assign in_bkt[1] = i_in_data.bucket_row1;
    assign in_bkt[2] = i_in_data.bucket_row2;
    assign in_bkt[3] = i_in_data.bucket_row3;

    assign row_addr = ADDR_W'(int'(r_row) * ROW_BUCKETS) + ADDR_W'(row_mod(r_bkt[r_row]));
    assign rd_cnt   = ram_rdata[WORD_W-1:FIELD_W];
    assign rd_sum   = ram_rdata[FIELD_W-1:0];
    assign cnt_inc  = {1'b0, rd_cnt} + (FIELD_W+1)'(1);
    assign sum_inc  = {1'b0, rd_sum} + (FIELD_W+1)'(r_delay);
    assign sat_cnt  = cnt_inc[FIELD_W] ? FIELD_MAX : cnt_inc[FIELD_W-1:0];
    assign sat_sum  = sum_inc[FIELD_W] ? FIELD_MAX : sum_inc[FIELD_W-1:0];
    assign min_cnt_now = (rd_cnt < r_min_cnt) ? rd_cnt : r_min_cnt;
    assign min_sum_now = (rd_sum < r_min_sum) ? rd_sum : r_min_sum;
    assign last_row = (r_row == ROWSEL_W'(ROWS - 1));
    assign rem_sh   = {r_rem[FIELD_W-1:0], r_quo[FIELD_W-1]};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_row       <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_row       <= n_row;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_delay   <= n_delay;
        r_bkt     <= n_bkt;
        r_min_cnt <= n_min_cnt;
        r_min_sum <= n_min_sum;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_row       = r_row;
        n_cmd       = r_cmd;
        n_delay     = r_delay;
        n_bkt       = r_bkt;
        n_min_cnt   = r_min_cnt;
        n_min_sum   = r_min_sum;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = row_addr;
        ram_wdata   = {sat_cnt, sat_sum};

        unique case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = t_cmd'(i_in_data.command);
                    n_delay   = i_in_data.delay;
                    for (int k = 0; k < ROWS; k++) begin
                        n_bkt[k] = in_bkt[k];
                    end
                    n_row     = '0;
                    n_min_cnt = FIELD_MAX;
                    n_min_sum = FIELD_MAX;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (r_cmd == CMD_INSERT) begin
                    ram_we = 1'b1;
                end else begin
                    n_min_cnt = min_cnt_now;
                    n_min_sum = min_sum_now;
                end
                if (!last_row) begin
                    n_row   = r_row + ROWSEL_W'(1);
                    n_state = S_RD;
                end else if (r_cmd == CMD_INSERT) begin
                    n_state = S_IDLE;
                end else if (min_cnt_now == '0) begin
                    n_quo   = '0;
                    n_state = S_DONE;
                end else begin
                    n_quo     = min_sum_now;
                    n_rem     = '0;
                    n_div_cnt = '0;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, r_min_cnt}) begin
                    n_rem = rem_sh - {1'b0, r_min_cnt};
                    n_quo = {r_quo[FIELD_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_quo = {r_quo[FIELD_W-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt + DIVCNT_W'(1);
                if (r_div_cnt == DIVCNT_W'(FIELD_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to drain before loading
                if (!r_out_valid || i_out_ready) begin
                    n_out.average     = r_quo;
                    n_out.empty_res   = (r_min_cnt == '0);
                    n_out.least_count = r_min_cnt;
                    n_out.min_sum     = r_min_sum;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMP(a_done_is_query, i_clk, i_rst_n, r_state == S_DONE, r_cmd == CMD_QUERY)
    `ASSERT_IMP(a_empty_zero_avg, i_clk, i_rst_n, r_out_valid && r_out.empty_res,
                r_out.average == '0 && r_out.least_count == '0)
    `ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_min_cnt != '0)
    `ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n,
                r_state == S_DONE && (!r_out_valid || i_out_ready),
                o_out_valid && r_state == S_IDLE)

endmodule

`default_nettype wire
